// ----- hdl/sgd_linear_fit_step_core_defines.svh -----
// Assertion macros for the SGD linear fit core checker.
`ifndef SGD_LINEAR_FIT_STEP_CORE_DEFINES_SVH
`define SGD_LINEAR_FIT_STEP_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, idle in reset.
`define SGDFIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, idle in reset.
`define SGDFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sgdfit_pkg.sv -----
// Shared types and constants for the SGD linear fit core.
package sgdfit_pkg;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic CFG_NUM_POINTS = 1'b0;
	localparam logic CFG_BASE_RATE  = 1'b1;

	localparam logic [15:0] NUM_POINTS_RST = 16'd1;
	localparam logic [15:0] BASE_RATE_RST  = 16'd655;

	localparam logic [64:0] DELTA_CLAMP = 65'h2_0000_0000;

	typedef struct packed {
		logic               command;
		logic        [1:0]  param_index;
		logic signed [31:0] param_value;
		logic signed [31:0] feature_0;
		logic signed [31:0] feature_1;
		logic signed [31:0] feature_2;
		logic signed [31:0] target;
		logic        [31:0] sample_weight;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] estimate;
		logic signed [31:0] error;
		logic signed [31:0] param_out_0;
		logic signed [31:0] param_out_1;
		logic signed [31:0] param_out_2;
	} result_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic signed [31:0] sat51(input logic signed [50:0] v);
		if (v > 51'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -51'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -36'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

endpackage

// ----- hdl/sgdfit_div.sv -----
// Restoring radix-2 divider, one quotient bit per cycle, clamped result.
module sgdfit_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [64:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [33:0] quotient
);

	logic [64:0] dvd_q;
	logic [31:0] rem_q;
	logic [31:0] dsr_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, dvd_q[64]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			rem_q  <= '0;
			dsr_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == 7'd1);
			if (start) begin
				dvd_q  <= dividend;
				rem_q  <= '0;
				dsr_q  <= divisor;
				cnt_q  <= 7'd65;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
				dvd_q <= {dvd_q[63:0], fits};
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = (dvd_q > sgdfit_pkg::DELTA_CLAMP) ? sgdfit_pkg::DELTA_CLAMP[33:0]
		: dvd_q[33:0];

endmodule

// ----- hdl/sgd_linear_fit_step_core.sv -----
// SGD linear fit step core: one 32x32 multiplier and one serial divider under a sequencer.
// For a sample item, each parameter update runs five passes through the
// shared 32x32 multiplier and a restoring divider, and the updates run one
// after another. The block takes one item at a time; a finished result waits
// in its output register while the next item is accepted, and an item that
// finishes while that register is still stalled waits until it drains.
// cfg_ready is always high.
module sgd_linear_fit_step_core #(
	parameter int NUM_PARAMS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  sgdfit_pkg::sample_t sample,
	output logic                result_valid,
	input  logic                result_stall,
	output sgdfit_pkg::result_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int IW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV, ST_SCL, ST_SCLW, ST_EMUL, ST_EACC, ST_ERR,
		ST_AMUL, ST_ACAP, ST_PPM, ST_PPA, ST_DIVD, ST_UPD, ST_FIN
	} state_t;

	state_t                  state_q;
	sgdfit_pkg::sample_t     smp_q;
	sgdfit_pkg::result_t     result_q;
	logic                    result_valid_q;
	logic signed [31:0]      params_q [NUM_PARAMS];
	logic [15:0]             cnt_q;
	logic [15:0]             num_points_q;
	logic [15:0]             base_rate_q;
	logic [IW-1:0]           idx_q;
	logic [1:0]              k_q;
	logic [63:0]             prod_q;
	logic [31:0]             div_q;
	logic [48:0]             scale_q;
	logic [63:0]             a_q;
	logic [112:0]            n_q;
	logic signed [50:0]      acc_q;
	logic signed [31:0]      est_q;
	logic signed [31:0]      err_q;
	logic                    neg_q;
	logic                    div_start_q;

	logic [31:0]             mul_a;
	logic [31:0]             mul_b;
	logic signed [31:0]      p_cur;
	logic signed [31:0]      f_cur;
	logic [15:0]             np;
	logic                    last;
	logic signed [31:0]      est_sat;
	logic [50:0]             term;
	logic [112:0]            pp_sh;
	logic                    div_done;
	logic [33:0]             div_quo;
	logic signed [35:0]      delta;
	logic signed [35:0]      upd_sum;
	logic signed [31:0]      pout [3];

	assign np    = (num_points_q == 16'd0) ? 16'd1 : num_points_q;
	assign p_cur = params_q[idx_q];
	assign last  = (32'(idx_q) == NUM_PARAMS - 1);

	always_comb begin
		case (32'(idx_q))
			0:       f_cur = smp_q.feature_0;
			1:       f_cur = smp_q.feature_1;
			2:       f_cur = smp_q.feature_2;
			default: f_cur = '0;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DIV: begin
				mul_a = 32'({1'b0, cnt_q} + 17'd1);
				mul_b = 32'(np);
			end
			ST_SCL: begin
				mul_a = 32'(base_rate_q);
				mul_b = smp_q.sample_weight;
			end
			ST_EMUL: begin
				mul_a = sgdfit_pkg::mag32(p_cur);
				mul_b = sgdfit_pkg::mag32(f_cur);
			end
			ST_AMUL: begin
				mul_a = sgdfit_pkg::mag32(err_q);
				mul_b = sgdfit_pkg::mag32(f_cur);
			end
			ST_PPM: begin
				mul_a = k_q[1] ? a_q[63:32] : a_q[31:0];
				mul_b = k_q[0] ? 32'(scale_q[48:32]) : scale_q[31:0];
			end
			default: ;
		endcase
	end

	assign est_sat = sgdfit_pkg::sat51(acc_q);
	assign term    = {3'b000, prod_q[63:16]};

	always_comb begin
		case (k_q)
			2'd0:    pp_sh = 113'(prod_q);
			2'd3:    pp_sh = 113'(prod_q) << 64;
			default: pp_sh = 113'(prod_q) << 32;
		endcase
	end

	assign delta   = neg_q ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
	assign upd_sum = 36'(p_cur) + delta;

	sgdfit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (n_q[112:48]),
		.divisor  (div_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	for (genvar j = 0; j < 3; j++) begin : g_pout
		if (j < NUM_PARAMS) begin : g_on
			assign pout[j] = params_q[j];
		end else begin : g_off
			assign pout[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			smp_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < NUM_PARAMS; i++) params_q[i] <= '0;
			cnt_q          <= '0;
			num_points_q   <= sgdfit_pkg::NUM_POINTS_RST;
			base_rate_q    <= sgdfit_pkg::BASE_RATE_RST;
			idx_q          <= '0;
			k_q            <= '0;
			prod_q         <= '0;
			div_q          <= '0;
			scale_q        <= '0;
			a_q            <= '0;
			n_q            <= '0;
			acc_q          <= '0;
			est_q          <= '0;
			err_q          <= '0;
			neg_q          <= 1'b0;
			div_start_q    <= 1'b0;
		end else begin
			prod_q      <= mul_a * mul_b;
			div_start_q <= (state_q == ST_PPA) && (k_q == 2'd3);
			if (result_valid_q && !result_stall && state_q != ST_FIN)
				result_valid_q <= 1'b0;
			if (cfg_valid) begin
				unique case (cfg_index)
					sgdfit_pkg::CFG_NUM_POINTS: num_points_q <= cfg_data;
					sgdfit_pkg::CFG_BASE_RATE:  base_rate_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						smp_q <= sample;
						idx_q <= '0;
						if (sample.command == sgdfit_pkg::CMD_LOAD) begin
							if (32'(sample.param_index) < NUM_PARAMS)
								params_q[IW'(sample.param_index)] <= sample.param_value;
							cnt_q   <= '0;
							est_q   <= '0;
							err_q   <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV:  state_q <= ST_SCL;
				ST_SCL: begin
					div_q   <= prod_q[31:0];
					state_q <= ST_SCLW;
				end
				ST_SCLW: begin
					scale_q <= {prod_q[47:0], 1'b0};
					acc_q   <= '0;
					state_q <= ST_EMUL;
				end
				ST_EMUL: begin
					neg_q   <= p_cur[31] ^ f_cur[31];
					state_q <= ST_EACC;
				end
				ST_EACC: begin
					acc_q <= neg_q ? acc_q - $signed(term) : acc_q + $signed(term);
					if (last) begin
						idx_q   <= '0;
						state_q <= ST_ERR;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_EMUL;
					end
				end
				ST_ERR: begin
					est_q   <= est_sat;
					err_q   <= sgdfit_pkg::sat33(33'(smp_q.target) - 33'(est_sat));
					state_q <= ST_AMUL;
				end
				ST_AMUL: begin
					neg_q   <= err_q[31] ^ f_cur[31];
					state_q <= ST_ACAP;
				end
				ST_ACAP: begin
					a_q     <= prod_q;
					n_q     <= '0;
					k_q     <= '0;
					state_q <= ST_PPM;
				end
				ST_PPM:  state_q <= ST_PPA;
				ST_PPA: begin
					n_q <= n_q + pp_sh;
					k_q <= k_q + 2'd1;
					if (k_q == 2'd3) begin
						state_q <= ST_DIVD;
					end else begin
						state_q <= ST_PPM;
					end
				end
				ST_DIVD: if (div_done) state_q <= ST_UPD;
				ST_UPD: begin
					params_q[idx_q] <= sgdfit_pkg::sat36(upd_sum);
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_AMUL;
					end
				end
				ST_FIN: begin
					if (!result_valid_q || !result_stall) begin
						result_q.estimate    <= est_q;
						result_q.error       <= err_q;
						result_q.param_out_0 <= pout[0];
						result_q.param_out_1 <= pout[1];
						result_q.param_out_2 <= pout[2];
						result_valid_q       <= 1'b1;
						if (smp_q.command == sgdfit_pkg::CMD_SAMPLE && cnt_q != 16'hFFFF)
							cnt_q <= cnt_q + 16'd1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

endmodule

// ----- hdl/sgdfit_chk.sv -----
// Port-level checker for the SGD linear fit core, bound to the top level.
`include "sgd_linear_fit_step_core_defines.svh"

module sgdfit_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                sample_valid,
	input logic                sample_stall,
	input logic                result_valid,
	input logic                result_stall,
	input sgdfit_pkg::result_t result
);

	`SGDFIT_ASSERT_NEXT(a_busy_after_accept, sample_valid && !sample_stall, sample_stall, "accepted transaction did not make the core busy")
	`SGDFIT_ASSERT_NOW(a_result_from_busy, $rose(result_valid), $past(sample_stall), "result appeared without a transaction in flight")
	`SGDFIT_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid, "stalled result dropped")
	`SGDFIT_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result), "stalled result changed")

endmodule

bind sgd_linear_fit_step_core sgdfit_chk u_sgdfit_chk (.*);

// ----- test/sgd_linear_fit_step_core_tb.sv -----
// Self-checking testbench for the SGD linear fit step core: directed and random traffic against a predictor.
module sgd_linear_fit_step_core_tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	sgdfit_pkg::sample_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	sgdfit_pkg::result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	sgd_linear_fit_step_core uut (.*);

	always #5 clk = ~clk;

	sgdfit_pkg::sample_t pend_items[$];
	sgdfit_pkg::result_t want_results[$];
	longint fit_params[3];
	int unsigned seen_count;
	logic [15:0] points_reg = sgdfit_pkg::NUM_POINTS_RST;
	logic [15:0] rate_reg = sgdfit_pkg::BASE_RATE_RST;
	int n_mismatch = 0, n_in = 0, n_out = 0, n_cfg = 0, stuck = 0;
	logic in_took = 1'b0;
	bit calm = 0;
	bit held_once = 0;
	int src_gap = 0, sink_gap = 0;

	function automatic longint sat_q(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic sgdfit_pkg::result_t fit_step(input sgdfit_pkg::sample_t s);
		sgdfit_pkg::result_t r;
		longint feat[3];
		longint sum, est, err;
		longint unsigned np, div, scale, emag, fmag;
		logic [127:0] num, quo;
		longint d;
		r = '0;
		est = 0;
		err = 0;
		if (s.command == sgdfit_pkg::CMD_LOAD) begin
			if (s.param_index < 3) fit_params[s.param_index] = longint'(s.param_value);
			seen_count = 0;
		end else begin
			np = (points_reg == 0) ? 1 : points_reg;
			div = (longint'(seen_count) + 1) * np;
			scale = longint'(rate_reg) * 2 * longint'(s.sample_weight);
			feat[0] = longint'(s.feature_0);
			feat[1] = longint'(s.feature_1);
			feat[2] = longint'(s.feature_2);
			sum = 0;
			for (int i = 0; i < 3; i++) sum += (fit_params[i] * feat[i]) / 64'sd65536;
			est = sat_q(sum);
			err = sat_q(longint'(s.target) - est);
			emag = err < 0 ? -err : err;
			for (int i = 0; i < 3; i++) begin
				fmag = feat[i] < 0 ? -feat[i] : feat[i];
				num = {64'b0, emag * fmag} * {64'b0, scale};
				quo = num / {64'b0, div};
				quo = quo >> 48;
				d = (quo > 128'h2_0000_0000) ? 64'sh2_0000_0000 : longint'(quo[63:0]);
				if ((err < 0) != (feat[i] < 0)) d = -d;
				fit_params[i] = sat_q(fit_params[i] + d);
			end
			if (seen_count < 65535) seen_count++;
		end
		r.estimate = est[31:0];
		r.error = err[31:0];
		r.param_out_0 = fit_params[0][31:0];
		r.param_out_1 = fit_params[1][31:0];
		r.param_out_2 = fit_params[2][31:0];
		return r;
	endfunction

	// input side monitor, output checker, config tracker, watchdog
	always @(posedge clk) begin
		sgdfit_pkg::result_t w;
		in_took <= sample_valid && !sample_stall;
		if (arst_n) begin
			stuck <= ((sample_valid && !sample_stall) || (result_valid && !result_stall)) ?
				0 : stuck + 1;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == sgdfit_pkg::CFG_NUM_POINTS) points_reg = cfg_data;
				else rate_reg = cfg_data;
				n_cfg++;
			end
			if (sample_valid && !sample_stall) begin
				want_results.push_back(fit_step(sample));
				n_in++;
			end
			if (result_valid && !result_stall) begin
				n_out++;
				if (want_results.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10) $display("unexpected transaction: %p", result);
				end else begin
					w = want_results.pop_front();
					if (w.estimate !== result.estimate || w.error !== result.error ||
					    w.param_out_0 !== result.param_out_0 ||
					    w.param_out_1 !== result.param_out_1 ||
					    w.param_out_2 !== result.param_out_2) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("mismatch #%0d", n_in);
							$display("  est exp %0d got %0d", w.estimate, result.estimate);
							$display("  err exp %0d got %0d", w.error, result.error);
							$display("  p0 exp %0d got %0d", w.param_out_0, result.param_out_0);
							$display("  p1 exp %0d got %0d", w.param_out_1, result.param_out_1);
							$display("  p2 exp %0d got %0d", w.param_out_2, result.param_out_2);
						end
					end
				end
			end
			if (stuck >= 6000) begin
				$display("watchdog: no transaction for %0d cycles", stuck);
				$display("** sgd_linear_fit_step_core: FAILED **");
				$finish;
			end
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || in_took)) begin
			if (src_gap > 0) begin
				src_gap <= src_gap - 1;
				sample_valid <= 1'b0;
			end else if (pend_items.size() > 0) begin
				sample <= pend_items.pop_front();
				sample_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 12);
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off so the core backs up
	always @(negedge clk) begin
		if (sink_gap > 0) begin
			sink_gap <= sink_gap - 1;
			result_stall <= 1'b1;
		end else if (!held_once && n_in >= 300) begin
			held_once <= 1;
			sink_gap <= 1500;
			result_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			sink_gap <= $urandom_range(0, 11);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] pick_q(input bit full);
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom;
			3: return full ? $urandom : $urandom_range(0, 1 << 17) - (1 << 16);
			default: return $urandom_range(0, 1 << 19) - (1 << 18);
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 1 << 18);
		endcase
	endfunction

	function automatic sgdfit_pkg::sample_t make_load(input logic [1:0] idx,
		input logic [31:0] v);
		sgdfit_pkg::sample_t s;
		s = '0;
		s.command = sgdfit_pkg::CMD_LOAD;
		s.param_index = idx;
		s.param_value = v;
		s.feature_0 = $urandom;
		s.target = $urandom;
		return s;
	endfunction

	function automatic sgdfit_pkg::sample_t make_sample(input bit full);
		sgdfit_pkg::sample_t s;
		s.command = sgdfit_pkg::CMD_SAMPLE;
		s.param_index = 2'($urandom);
		s.param_value = $urandom;
		s.feature_0 = pick_q(full);
		s.feature_1 = pick_q(full);
		s.feature_2 = pick_q(full);
		s.target = pick_q(full);
		s.sample_weight = pick_weight();
		return s;
	endfunction

	task automatic settle();
		while (pend_items.size() > 0 || sample_valid || want_results.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] np_set[6];
		logic [15:0] br_set[6];
		sgdfit_pkg::sample_t s;
		np_set = '{16'd1, 16'd0, 16'd65535, 16'd10, 16'd3, 16'd1000};
		br_set = '{16'd655, 16'd65535, 16'd0, 16'd30000, 16'd1, 16'd655};
		fit_params = '{0, 0, 0};
		seen_count = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		pend_items.push_back(make_load(2'd0, 32'h7FFF_FFFF));
		pend_items.push_back(make_load(2'd1, 32'h8000_0000));
		pend_items.push_back(make_load(2'd2, 32'h0001_0000));
		pend_items.push_back(make_load(2'd3, 32'h1234_5678));
		s = make_sample(0);
		s.feature_0 = 32'h7FFF_FFFF; s.feature_1 = 32'h8000_0000; s.feature_2 = 32'h0;
		s.target = 32'h7FFF_FFFF; s.sample_weight = 32'hFFFF_FFFF;
		pend_items.push_back(s);
		s.target = 32'h8000_0000; s.sample_weight = 32'h0;
		pend_items.push_back(s);
		s.feature_0 = 32'h0; s.feature_1 = 32'h0; s.feature_2 = 32'h0; s.target = 32'h0;
		pend_items.push_back(s);
		for (int k = 0; k < 3; k++) pend_items.push_back(make_load(2'(k), 32'h0));
		for (int k = 0; k < 8; k++) pend_items.push_back(make_sample(k[0]));
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				write_reg(sgdfit_pkg::CFG_NUM_POINTS, np_set[ph]);
				write_reg(sgdfit_pkg::CFG_BASE_RATE, br_set[ph]);
			end
			if (ph == 5) calm = 1;
			for (int k = 0; k < 255; k++) begin
				if ($urandom_range(0, 29) == 0) begin
					for (int j = 0; j < 3; j++)
						pend_items.push_back(make_load(2'(j), pick_q(1)));
					if ($urandom_range(0, 3) == 0)
						pend_items.push_back(make_load(2'd3, $urandom));
				end else begin
					pend_items.push_back(make_sample($urandom_range(0, 4) == 0));
				end
			end
			settle();
		end

		$display("%0d items in, %0d results checked, %0d register writes, six rate settings",
			n_in, n_out, n_cfg);
		if (n_mismatch == 0 && want_results.size() == 0) begin
			$display("** sgd_linear_fit_step_core: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results missing", n_mismatch, want_results.size());
			$display("** sgd_linear_fit_step_core: FAILED **");
		end
		$finish;
	end

endmodule
